// ===== hw/rtl/pos_list_pkg.sv =====
// Shared constants for the positional list engine: field widths, request
// and status codes, default sizes. No dependencies.
`default_nettype none

package pos_list_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int ELEM_WIDTH_DEF = 32;

   localparam int FUNC_W = 3;
   localparam int POS_W  = 7;
   localparam int VAL_W  = 32;
   localparam int STAT_W = 2;
   localparam int LEN_W  = 7;

   localparam logic [FUNC_W-1:0] FN_ADD_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FN_ADD_REAR  = 3'd1;
   localparam logic [FUNC_W-1:0] FN_REM_FRONT = 3'd2;
   localparam logic [FUNC_W-1:0] FN_REM_REAR  = 3'd3;
   localparam logic [FUNC_W-1:0] FN_INS_AT    = 3'd4;
   localparam logic [FUNC_W-1:0] FN_DEL_AT    = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE     = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/pos_list_store.sv =====
// Element store of the positional list engine: one write port, one read
// port with registered read data. Uses pos_list_pkg only for defaults.
`default_nettype none

module pos_list_store
   import pos_list_pkg::*;
#(
   parameter int DEPTH = CAPACITY_DEF,
   parameter int WIDTH = ELEM_WIDTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pos_list_ctrl.sv =====
// Sequencer of the positional list engine: decodes a request, checks it,
// shifts stored words one per cycle through the store and builds the result.
// Depends on pos_list_pkg.
`default_nettype none

module pos_list_ctrl
   import pos_list_pkg::*;
#(
   parameter int DEPTH = CAPACITY_DEF,
   parameter int WIDTH = ELEM_WIDTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [POS_W-1:0]  req_position,
   input  wire logic [VAL_W-1:0]  req_item_value,
   output logic                   rsp_strobe,
   output logic [VAL_W-1:0]       rsp_removed_value,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [LEN_W-1:0]       rsp_length,
   output logic                   rsp_is_empty,
   output logic                   mem_wr_en,
   output logic [AW-1:0]          mem_wr_addr,
   output logic [WIDTH-1:0]       mem_wr_data,
   output logic                   mem_rd_en,
   output logic [AW-1:0]          mem_rd_addr,
   input  wire logic [WIDTH-1:0]  mem_rd_data
);

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MOVE  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_PUT   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [AW-1:0]     stop_ff, stop_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [WIDTH-1:0]  val_ff, val_in;
   logic              ins_ff, ins_in;
   logic              pend_ff, pend_in;
   logic              cap_ff, cap_in;
   logic [AW-1:0]     pdst_ff, pdst_in;
   logic [WIDTH-1:0]  rem_ff, rem_in;

   logic              strobe_ff, strobe_in;
   logic [WIDTH-1:0]  out_rem_ff, out_rem_in;
   logic [STAT_W-1:0] out_stat_ff, out_stat_in;
   logic [CW-1:0]     out_len_ff, out_len_in;

   logic              accept;
   logic              full;
   logic              empty;
   logic [CMPW-1:0]   pos_x;
   logic [CMPW-1:0]   cnt_x;
   logic [WIDTH-1:0]  in_val;
   logic [STAT_W-1:0] chk_stat;
   logic              do_ins;
   logic              do_del;
   logic [AW-1:0]     op_idx;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);
   assign full   = (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);
   assign pos_x  = CMPW'(req_position);
   assign cnt_x  = CMPW'(count_ff);
   assign in_val = WIDTH'(64'(req_item_value));

   // request check and slot selection
   always_comb begin
      chk_stat = ST_OK;
      do_ins   = 1'b0;
      do_del   = 1'b0;
      op_idx   = '0;
      unique case (req_func)
         FN_ADD_FRONT: begin
            if (full) chk_stat = ST_FULL;
            else      do_ins   = 1'b1;
         end
         FN_ADD_REAR: begin
            op_idx = AW'(count_ff);
            if (full) chk_stat = ST_FULL;
            else      do_ins   = 1'b1;
         end
         FN_REM_FRONT: begin
            if (empty) chk_stat = ST_UNDERFLOW;
            else       do_del   = 1'b1;
         end
         FN_REM_REAR: begin
            op_idx = AW'(count_ff - 1'b1);
            if (empty) chk_stat = ST_UNDERFLOW;
            else       do_del   = 1'b1;
         end
         FN_INS_AT: begin
            op_idx = AW'(pos_x - 1'b1);
            // range check takes precedence over full
            if ((pos_x == '0) || (pos_x > cnt_x + 1'b1)) chk_stat = ST_RANGE;
            else if (full)                               chk_stat = ST_FULL;
            else                                         do_ins   = 1'b1;
         end
         FN_DEL_AT: begin
            op_idx = AW'(pos_x - 1'b1);
            if ((pos_x == '0) || (pos_x > cnt_x)) chk_stat = ST_RANGE;
            else                                  do_del   = 1'b1;
         end
         default: begin
            chk_stat = ST_OK;
         end
      endcase
   end

   // write port: shifted word from the previous read, or the new word
   always_comb begin
      if (state_ff == S_PUT) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = idx_ff;
         mem_wr_data = val_ff;
      end else begin
         mem_wr_en   = pend_ff && !cap_ff;
         mem_wr_addr = pdst_ff;
         mem_wr_data = mem_rd_data;
      end
   end

   assign mem_rd_en   = (state_ff == S_MOVE);
   assign mem_rd_addr = rd_ptr_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rd_ptr_in   = rd_ptr_ff;
      stop_in     = stop_ff;
      idx_in      = idx_ff;
      val_in      = val_ff;
      ins_in      = ins_ff;
      pend_in     = 1'b0;
      cap_in      = 1'b0;
      pdst_in     = pdst_ff;
      rem_in      = (pend_ff && cap_ff) ? mem_rd_data : rem_ff;
      strobe_in   = 1'b0;
      out_rem_in  = out_rem_ff;
      out_stat_in = out_stat_ff;
      out_len_in  = out_len_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in = op_idx;
               val_in = in_val;
               if (do_ins) begin
                  ins_in = 1'b1;
                  if (CW'(op_idx) == count_ff) begin
                     state_in = S_PUT;
                  end else begin
                     state_in  = S_MOVE;
                     rd_ptr_in = AW'(count_ff - 1'b1);
                     stop_in   = op_idx;
                  end
               end else if (do_del) begin
                  ins_in    = 1'b0;
                  state_in  = S_MOVE;
                  rd_ptr_in = op_idx;
                  stop_in   = AW'(count_ff - 1'b1);
               end else begin
                  strobe_in   = 1'b1;
                  out_rem_in  = '0;
                  out_stat_in = chk_stat;
                  out_len_in  = count_ff;
               end
            end
         end
         S_MOVE: begin
            pend_in = 1'b1;
            // first read of a delete is the removed word, not a move
            cap_in  = !ins_ff && (rd_ptr_ff == idx_ff);
            pdst_in = ins_ff ? rd_ptr_ff + 1'b1 : rd_ptr_ff - 1'b1;
            if (rd_ptr_ff == stop_ff) begin
               state_in = S_DRAIN;
            end else begin
               rd_ptr_in = ins_ff ? rd_ptr_ff - 1'b1 : rd_ptr_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            if (ins_ff) begin
               state_in = S_PUT;
            end else begin
               state_in    = S_IDLE;
               count_in    = count_ff - 1'b1;
               strobe_in   = 1'b1;
               out_rem_in  = (pend_ff && cap_ff) ? mem_rd_data : rem_ff;
               out_stat_in = ST_OK;
               out_len_in  = count_ff - 1'b1;
            end
         end
         S_PUT: begin
            state_in    = S_IDLE;
            count_in    = count_ff + 1'b1;
            strobe_in   = 1'b1;
            out_rem_in  = '0;
            out_stat_in = ST_OK;
            out_len_in  = count_ff + 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      stop_ff     <= stop_in;
      idx_ff      <= idx_in;
      val_ff      <= val_in;
      ins_ff      <= ins_in;
      cap_ff      <= cap_in;
      pdst_ff     <= pdst_in;
      rem_ff      <= rem_in;
      out_rem_ff  <= out_rem_in;
      out_stat_ff <= out_stat_in;
      out_len_ff  <= out_len_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_removed_value = VAL_W'(64'(out_rem_ff));
   assign rsp_status        = out_stat_ff;
   assign rsp_length        = LEN_W'(out_len_ff);
   assign rsp_is_empty      = (out_len_ff == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/positional_list_engine.sv =====
// Top level of the positional list engine: sequencer plus element store.
// Depends on pos_list_pkg, pos_list_ctrl, pos_list_store.
//
//   channel   ports                                   handshake
//   request   req_func, req_position, req_item_value  start & !busy
//   result    rsp_removed_value, rsp_status,          rsp_strobe, one cycle
//             rsp_length, rsp_is_empty
//
// A rejected or no-op request gives its result the cycle after acceptance.
// Insert/add: one store read per word moved toward the rear (count - slot),
// a drain state, then one write of the new word; adding at the rear goes
// straight to the write. Delete/remove: one read per word from the slot to
// the rear, then a drain that gives the result. Moves are paced by the
// single store read port.
// Reset empties the list at once; the store itself is never cleared.
// Results cannot be stalled; the next request may start while one is shown.
`default_nettype none

module positional_list_engine
   import pos_list_pkg::*;
#(
   parameter int CAPACITY   = CAPACITY_DEF,
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [FUNC_W-1:0] req_func,
   input  wire logic [POS_W-1:0]  req_position,
   input  wire logic [VAL_W-1:0]  req_item_value,
   output logic                   rsp_strobe,
   output logic [VAL_W-1:0]       rsp_removed_value,
   output logic [STAT_W-1:0]      rsp_status,
   output logic [LEN_W-1:0]       rsp_length,
   output logic                   rsp_is_empty
);

   localparam int AW = $clog2(CAPACITY);

   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [ELEM_WIDTH-1:0] mem_wr_data;
   logic                  mem_rd_en;
   logic [AW-1:0]         mem_rd_addr;
   logic [ELEM_WIDTH-1:0] mem_rd_data;

   pos_list_ctrl #(
      .DEPTH (CAPACITY),
      .WIDTH (ELEM_WIDTH),
      .AW    (AW)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_position      (req_position),
      .req_item_value    (req_item_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_length        (rsp_length),
      .rsp_is_empty      (rsp_is_empty),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_en         (mem_rd_en),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data)
   );

   pos_list_store #(
      .DEPTH (CAPACITY),
      .WIDTH (ELEM_WIDTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire

// ===== dv/positional_list_engine_tb.sv =====
// Self-checking testbench for positional_list_engine: directed corner words, then
// random grow/shrink/mixed traffic checked against a list predictor.
// Depends on pos_list_pkg and the positional_list_engine RTL.

module positional_list_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pos_list_pkg::*;

   localparam int DEPTH         = CAPACITY_DEF;
   localparam int WORD_TARGET   = 650;
   localparam int SETTLE_CYCLES = DEPTH + 8;

   // func codes the block treats as no-ops
   localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

   typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED} drift_type;

   typedef struct packed {
      logic [VAL_W-1:0]  removed_value;
      logic [STAT_W-1:0] status;
      logic [LEN_W-1:0]  length;
      logic              is_empty;
   } list_result_type;

   class list_scoreboard_type;
      logic [VAL_W-1:0] slots [CAPACITY_DEF];
      int               count;
      list_result_type  expected [$];
      int               errors;

      function new();
         count  = 0;
         errors = 0;
      endfunction

      function void put_at(int idx, logic [VAL_W-1:0] v);
         for (int k = count; k > idx; k--)
            slots[k] = slots[k-1];
         slots[idx] = v;
         count++;
      endfunction

      function logic [VAL_W-1:0] take_at(int idx);
         logic [VAL_W-1:0] v;
         v = slots[idx];
         for (int k = idx; k + 1 < count; k++)
            slots[k] = slots[k+1];
         count--;
         return v;
      endfunction

      function void note_request(logic [FUNC_W-1:0] fn, logic [POS_W-1:0] pos,
                                 logic [VAL_W-1:0] val);
         list_result_type r;
         int              p;
         r = '0;
         r.status = ST_OK;
         p = int'(pos);
         case (fn)
            FN_ADD_FRONT, FN_ADD_REAR: begin
               if (count >= CAPACITY_DEF) r.status = ST_FULL;
               else put_at((fn == FN_ADD_FRONT) ? 0 : count, val);
            end
            FN_REM_FRONT, FN_REM_REAR: begin
               if (count == 0) r.status = ST_UNDERFLOW;
               else r.removed_value = take_at((fn == FN_REM_FRONT) ? 0 : count - 1);
            end
            FN_INS_AT: begin
               // range check wins over full
               if (p < 1 || p > count + 1) r.status = ST_RANGE;
               else if (count >= CAPACITY_DEF) r.status = ST_FULL;
               else put_at(p - 1, val);
            end
            FN_DEL_AT: begin
               if (p < 1 || p > count) r.status = ST_RANGE;
               else r.removed_value = take_at(p - 1);
            end
            default: ;
         endcase
         r.length   = LEN_W'(count);
         r.is_empty = (count == 0);
         expected.push_back(r);
      endfunction

      task report(string msg);
         $display("ERROR at %0t ns: %s", $time, msg);
         errors++;
      endtask

      task check_result(list_result_type got);
         list_result_type want;
         if (expected.size() == 0) begin
            report($sformatf("result word with nothing outstanding: %h", got));
            return;
         end
         want = expected.pop_front();
         if (got.removed_value !== want.removed_value)
            report($sformatf("removed_value %h, want %h", got.removed_value,
                             want.removed_value));
         if (got.status !== want.status)
            report($sformatf("status %0d, want %0d", got.status, want.status));
         if (got.length !== want.length)
            report($sformatf("length %0d, want %0d", got.length, want.length));
         if (got.is_empty !== want.is_empty)
            report($sformatf("is_empty %b, want %b", got.is_empty, want.is_empty));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   logic [FUNC_W-1:0] req_func;
   logic [POS_W-1:0]  req_position;
   logic [VAL_W-1:0]  req_item_value;
   logic              rsp_strobe;
   logic [VAL_W-1:0]  rsp_removed_value;
   logic [STAT_W-1:0] rsp_status;
   logic [LEN_W-1:0]  rsp_length;
   logic              rsp_is_empty;

   list_scoreboard_type sb;
   list_result_type     seen;
   bit                  burst;
   int                  words_sent;

   positional_list_engine #(
      .CAPACITY   (DEPTH),
      .ELEM_WIDTH (ELEM_WIDTH_DEF)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_position      (req_position),
      .req_item_value    (req_item_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_length        (rsp_length),
      .rsp_is_empty      (rsp_is_empty)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         seen.removed_value = rsp_removed_value;
         seen.status        = rsp_status;
         seen.length        = rsp_length;
         seen.is_empty      = rsp_is_empty;
         sb.check_result(seen);
      end
   end

   // start stays high across back-to-back words; it only drops for a gap
   task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_func       <= fn;
      req_position   <= pos;
      req_item_value <= val;
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_request(fn, pos, val);
      words_sent++;
   endtask

   function automatic int draw_gap();
      return burst ? 0 : $urandom_range(0, 4);
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return '0;
      if (roll < 10) return '1;
      return $urandom();
   endfunction

   function automatic logic [FUNC_W-1:0] pick_func(drift_type mode);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) return ($urandom_range(0, 1) == 0) ? FN_SPARE_LO : FN_SPARE_HI;
      case (mode)
         MODE_GROW: begin
            if (roll < 40) return FN_INS_AT;
            if (roll < 60) return FN_ADD_FRONT;
            if (roll < 80) return FN_ADD_REAR;
            if (roll < 90) return ($urandom_range(0, 1) == 0) ? FN_REM_FRONT : FN_REM_REAR;
            return FN_DEL_AT;
         end
         MODE_SHRINK: begin
            if (roll < 40) return FN_DEL_AT;
            if (roll < 60) return FN_REM_FRONT;
            if (roll < 80) return FN_REM_REAR;
            if (roll < 90) return ($urandom_range(0, 1) == 0) ? FN_ADD_FRONT : FN_ADD_REAR;
            return FN_INS_AT;
         end
         default: return FUNC_W'($urandom_range(FN_ADD_FRONT, FN_DEL_AT));
      endcase
   endfunction

   // mostly in-range positions, with a share of the edges just outside and of random ones
   function automatic logic [POS_W-1:0] pick_position(logic [FUNC_W-1:0] fn);
      int n;
      int roll;
      n    = sb.count;
      roll = $urandom_range(0, 99);
      if (fn == FN_INS_AT && roll < 85) return POS_W'($urandom_range(1, n + 1));
      if (fn == FN_DEL_AT && n > 0 && roll < 85) return POS_W'($urandom_range(1, n));
      case (roll % 4)
         0:       return '0;
         1:       return POS_W'(n + 1);
         2:       return POS_W'(n + 2);
         default: return POS_W'($urandom_range(0, 127));
      endcase
   endfunction

   initial begin
      logic [FUNC_W-1:0] fn;
      drift_type         mode;
      int                span;

      sb             = new();
      reset          = 1'b1;
      start          = 1'b0;
      req_func       = '0;
      req_position   = '0;
      req_item_value = '0;
      burst          = 1'b0;
      words_sent     = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty-list corners
      send_word(FN_REM_FRONT, 7'd0,   32'h0,        draw_gap());
      send_word(FN_REM_REAR,  7'd127, 32'hFFFFFFFF, draw_gap());
      send_word(FN_DEL_AT,    7'd1,   32'h0,        draw_gap());
      send_word(FN_INS_AT,    7'd0,   32'h12345678, draw_gap());
      send_word(FN_INS_AT,    7'd2,   32'h87654321, draw_gap());
      send_word(FN_SPARE_LO,  7'd0,   32'h0,        draw_gap());
      send_word(FN_SPARE_HI,  7'd127, 32'hFFFFFFFF, draw_gap());
      // build a short list, then pick it apart at both ends and the middle
      send_word(FN_ADD_FRONT, 7'd0,   32'hFFFFFFFF, draw_gap());
      send_word(FN_ADD_REAR,  7'd127, 32'h00000000, draw_gap());
      send_word(FN_INS_AT,    7'd1,   32'hA5A5A5A5, draw_gap());
      send_word(FN_INS_AT,    7'd4,   32'h5A5A5A5A, draw_gap());
      send_word(FN_INS_AT,    7'd3,   32'h0F0F0F0F, draw_gap());
      send_word(FN_INS_AT,    7'd127, 32'hDEADBEEF, draw_gap());
      send_word(FN_DEL_AT,    7'd0,   32'h0,        draw_gap());
      send_word(FN_DEL_AT,    7'd6,   32'h0,        draw_gap());
      send_word(FN_DEL_AT,    7'd3,   32'h0,        draw_gap());
      send_word(FN_DEL_AT,    7'd4,   32'h0,        draw_gap());
      send_word(FN_DEL_AT,    7'd1,   32'h0,        draw_gap());
      send_word(FN_REM_FRONT, 7'd5,   32'h0,        draw_gap());
      send_word(FN_REM_REAR,  7'd0,   32'h0,        draw_gap());
      send_word(FN_INS_AT,    7'd1,   32'hC3C3C3C3, draw_gap());
      send_word(FN_REM_FRONT, 7'd0,   32'h0,        draw_gap());

      // fill to capacity with random content, then probe the full list
      while (sb.count < DEPTH) begin
         fn = pick_func(MODE_GROW);
         send_word(fn, pick_position(fn), pick_value(), draw_gap());
      end
      send_word(FN_ADD_FRONT, 7'd0,             pick_value(), draw_gap());
      send_word(FN_ADD_REAR,  7'd0,             pick_value(), draw_gap());
      send_word(FN_INS_AT,    7'd1,             pick_value(), draw_gap());
      send_word(FN_INS_AT,    POS_W'(DEPTH + 1), pick_value(), draw_gap());
      send_word(FN_INS_AT,    POS_W'(DEPTH + 2), pick_value(), draw_gap());
      send_word(FN_INS_AT,    7'd0,             pick_value(), draw_gap());
      send_word(FN_DEL_AT,    POS_W'(DEPTH),    pick_value(), draw_gap());
      send_word(FN_ADD_REAR,  7'd0,             pick_value(), draw_gap());

      while (words_sent < WORD_TARGET) begin
         mode  = drift_type'($urandom_range(0, 2));
         burst = ($urandom_range(0, 3) == 0);
         span  = $urandom_range(30, 120);
         repeat (span) begin
            if (words_sent >= WORD_TARGET) break;
            fn = pick_func(mode);
            send_word(fn, pick_position(fn), pick_value(), draw_gap());
         end
      end
      start <= 1'b0;

      while (sb.expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/pos_list_pkg.sv
hw/rtl/pos_list_store.sv
hw/rtl/pos_list_ctrl.sv
hw/rtl/positional_list_engine.sv
dv/positional_list_engine_tb.sv
